// ----- hdl/ctp_pkg.sv -----
// Shared types, constants and character helpers for the card track parser.
`timescale 1ns / 1ps

package ctp_pkg;

    // Longest swipe string; the byte at MAX_LEN-1 is read as a terminator.
    localparam int MAX_LEN = 256;
    localparam int POS_W = 8;

    localparam int CARD_W = 54;
    localparam int SID_W = 30;
    localparam int CNT_W = 5;
    localparam int TIDX_W = 4;

    localparam int CARD_DIGITS = 16;
    localparam int SID_DIGITS = 9;
    localparam int TRAILER_LEN = 12;

    // student_id / 1000000 is 860 or 861
    localparam logic [SID_W-1:0] ID_LOW = SID_W'(860000000);
    localparam logic [SID_W-1:0] ID_HIGH = SID_W'(861999999);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef struct packed {
        logic       start_of_card;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic              parse_ok;
        logic              first_char_bad;
        logic [POS_W-1:0]  error_position;
        logic [CARD_W-1:0] card_number;
        logic [SID_W-1:0]  student_id;
        logic              id_in_range;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Fixed trailer "491212000000"
    function automatic logic [7:0] trailer_char(input logic [TIDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h34;
            4'd1:    ch = 8'h39;
            4'd2:    ch = 8'h31;
            4'd3:    ch = 8'h32;
            4'd4:    ch = 8'h31;
            4'd5:    ch = 8'h32;
            default: ch = 8'h30;
        endcase
        return ch;
    endfunction

endpackage

// ----- hdl/ctp_item_if.sv -----
// Valid/ready channel carrying one swipe byte request.
`timescale 1ns / 1ps

interface ctp_item_if;
    logic       valid;
    logic       ready;
    logic       start_of_card;
    logic [7:0] char_code;

    modport source (output valid, output start_of_card, output char_code, input ready);
    modport sink (input valid, input start_of_card, input char_code, output ready);
endinterface

// ----- hdl/ctp_result_if.sv -----
// Valid/ready channel carrying one parse result request.
`timescale 1ns / 1ps

interface ctp_result_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic        first_char_bad;
    logic [7:0]  error_position;
    logic [53:0] card_number;
    logic [29:0] student_id;
    logic        id_in_range;

    modport source (output valid, output parse_ok, output first_char_bad,
                    output error_position, output card_number, output student_id,
                    output id_in_range, input ready);
    modport sink (input valid, input parse_ok, input first_char_bad,
                  input error_position, input card_number, input student_id,
                  input id_in_range, output ready);
endinterface

// ----- hdl/ctp_in_stage.sv -----
// Input register for incoming swipe bytes.
`timescale 1ns / 1ps

module ctp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    ctp_item_if.sink           item,
    input  logic               advance,
    output logic               step_en,
    output ctp_pkg::item_t     step_item
);

    logic           valid_reg;
    ctp_pkg::item_t data_reg;

    assign item.ready = !valid_reg || advance;
    assign step_en = valid_reg && advance;
    assign step_item = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            data_reg.start_of_card <= item.start_of_card;
            data_reg.char_code <= item.char_code;
        end
    end

endmodule

// ----- hdl/ctp_parser.sv -----
// Track layout state machine: one byte step per enabled cycle.
`timescale 1ns / 1ps

module ctp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  ctp_pkg::item_t      step_item,
    output logic                res_valid,
    output ctp_pkg::result_t    res
);

    typedef enum logic [3:0] {
        PH_WAIT,
        PH_PREFIX,
        PH_CARD,
        PH_LAST,
        PH_FIRST,
        PH_SKIP,
        PH_TRAILER,
        PH_SID,
        PH_DONE
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [ctp_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [ctp_pkg::CNT_W-1:0]           dcnt_reg, dcnt_next;
    logic [ctp_pkg::CARD_W-1:0]          card_reg, card_next;
    logic [ctp_pkg::SID_W-1:0]           sid_reg, sid_next;
    logic [ctp_pkg::TIDX_W-1:0]          tidx_reg, tidx_next;

    phase_t                              ph;
    logic [ctp_pkg::POS_W-1:0]           pos;
    logic [ctp_pkg::CNT_W-1:0]           dcnt;
    logic [ctp_pkg::CNT_W-1:0]           dcnt_inc;
    logic [ctp_pkg::CARD_W-1:0]          card_acc;
    logic [ctp_pkg::SID_W-1:0]           sid_acc;
    logic [ctp_pkg::TIDX_W-1:0]          tidx;
    logic [7:0]                          c;
    logic                                fail;
    logic                                success;
    logic [ctp_pkg::POS_W:0]             fail_pos;

    always_comb
    begin
        // a start byte restarts everything and is itself position 0
        ph = step_item.start_of_card ? PH_PREFIX : phase_reg;
        pos = step_item.start_of_card ? '0 : pos_reg;
        dcnt = step_item.start_of_card ? '0 : dcnt_reg;
        card_acc = step_item.start_of_card ? '0 : card_reg;
        sid_acc = step_item.start_of_card ? '0 : sid_reg;
        tidx = step_item.start_of_card ? '0 : tidx_reg;

        c = (pos >= ctp_pkg::POS_W'(ctp_pkg::MAX_LEN - 1)) ? ctp_pkg::CH_NUL
                                                           : step_item.char_code;
        dcnt_inc = dcnt + 1'b1;

        phase_next = ph;
        pos_next = pos;
        dcnt_next = dcnt;
        card_next = card_acc;
        sid_next = sid_acc;
        tidx_next = tidx;
        fail = 1'b0;
        success = 1'b0;
        fail_pos = {1'b0, pos};

        if (ph != PH_WAIT && ph != PH_DONE)
        begin
            pos_next = pos + 1'b1;
        end

        unique case (ph)
            PH_WAIT, PH_DONE:
            begin
            end
            PH_PREFIX:
            begin
                if (c != ((pos == '0) ? ctp_pkg::CH_PERCENT : ctp_pkg::CH_B))
                    fail = 1'b1;
                else if (pos != '0)
                    phase_next = PH_CARD;
            end
            PH_CARD:
            begin
                if (c == ctp_pkg::CH_CARET && dcnt == ctp_pkg::CNT_W'(ctp_pkg::CARD_DIGITS))
                begin
                    dcnt_next = '0;
                    phase_next = PH_LAST;
                end
                else if (c == ctp_pkg::CH_CARET
                         || dcnt >= ctp_pkg::CNT_W'(ctp_pkg::CARD_DIGITS)
                         || !ctp_pkg::is_digit(c))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    card_next = (card_acc << 3) + (card_acc << 1)
                                + ctp_pkg::CARD_W'(c[3:0]);
                    dcnt_next = dcnt_inc;
                end
            end
            PH_LAST:
            begin
                if (c == ctp_pkg::CH_SLASH)
                    phase_next = PH_FIRST;
                else if (!ctp_pkg::is_letter(c) && c != ctp_pkg::CH_SPACE)
                    fail = 1'b1;
            end
            PH_FIRST:
            begin
                if (c == ctp_pkg::CH_SPACE)
                    phase_next = PH_SKIP;
                else if (!ctp_pkg::is_letter(c))
                    fail = 1'b1;
            end
            PH_SKIP:
            begin
                if (c == ctp_pkg::CH_NUL)
                    fail = 1'b1;
                else if (c == ctp_pkg::CH_CARET)
                begin
                    tidx_next = '0;
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (c == ctp_pkg::CH_NUL)
                    fail = 1'b1;
                else if (tidx >= ctp_pkg::TIDX_W'(ctp_pkg::TRAILER_LEN)
                         || c != ctp_pkg::trailer_char(tidx))
                begin
                    // mismatch is reported one past the offending byte
                    fail = 1'b1;
                    fail_pos = {1'b0, pos} + 1'b1;
                end
                else
                begin
                    tidx_next = tidx + 1'b1;
                    if (tidx_next == ctp_pkg::TIDX_W'(ctp_pkg::TRAILER_LEN))
                    begin
                        dcnt_next = '0;
                        phase_next = PH_SID;
                    end
                end
            end
            PH_SID:
            begin
                if (!ctp_pkg::is_digit(c))
                    fail = 1'b1;
                else
                begin
                    sid_next = (sid_acc << 3) + (sid_acc << 1)
                               + ctp_pkg::SID_W'(c[3:0]);
                    dcnt_next = dcnt_inc;
                    if (dcnt_inc >= ctp_pkg::CNT_W'(ctp_pkg::SID_DIGITS))
                    begin
                        success = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase

        if (fail)
            phase_next = PH_DONE;

        res_valid = step_en && (fail || success);
        res.parse_ok = success;
        res.first_char_bad = fail && (fail_pos == '0);
        res.error_position = fail ? fail_pos[ctp_pkg::POS_W-1:0] : '0;
        res.card_number = success ? card_acc : '0;
        res.student_id = success ? sid_next : '0;
        res.id_in_range = success && (sid_next >= ctp_pkg::ID_LOW)
                          && (sid_next <= ctp_pkg::ID_HIGH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            pos_reg <= '0;
            dcnt_reg <= '0;
            card_reg <= '0;
            sid_reg <= '0;
            tidx_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            dcnt_reg <= dcnt_next;
            card_reg <= card_next;
            sid_reg <= sid_next;
            tidx_reg <= tidx_next;
        end
    end

`ifndef ASSERT_OFF
    // a result closes the card until the next start
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> phase_reg == PH_DONE)
        else $error("parser not done after result");

    // no second result without a new start
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !step_item.start_of_card && phase_reg == PH_DONE |-> !res_valid)
        else $error("result from a finished card");

    // position moves by one on every byte of an open card
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !step_item.start_of_card && phase_reg != PH_WAIT
        && phase_reg != PH_DONE
        |=> pos_reg == ctp_pkg::POS_W'($past(pos_reg) + 1'b1))
        else $error("byte position skipped");
`endif

endmodule

// ----- hdl/ctp_out_stage.sv -----
// Result register in front of the result channel.
`timescale 1ns / 1ps

module ctp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  ctp_pkg::result_t    res,
    output logic                advance,
    ctp_result_if.source        result
);

    logic             valid_reg;
    ctp_pkg::result_t data_reg;

    // stage moves whenever the slot is empty or being drained
    assign advance = !valid_reg || result.ready;

    assign result.valid = valid_reg;
    assign result.parse_ok = data_reg.parse_ok;
    assign result.first_char_bad = data_reg.first_char_bad;
    assign result.error_position = data_reg.error_position;
    assign result.card_number = data_reg.card_number;
    assign result.student_id = data_reg.student_id;
    assign result.id_in_range = data_reg.id_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

// ----- hdl/card_track_parser.sv -----
// Top level of the card track parser.
`timescale 1ns / 1ps
//
// Swipe bytes arrive on the item channel (valid/ready), one byte per request,
// with start_of_card marking the first byte of a card. A byte of 0 ends the
// string. At most one request per card leaves on the result channel: success with the
// card number, student ID and range flag, or the first failing position.
// Bytes after a result are dropped until the next start.
//
// Throughput: one byte per cycle while the result register can advance.
// Each byte is one pass of the layout state machine between the input
// register and the result register.
// Path: the parser steps a byte when the result register advances, which
// loads the result at that same edge (input register, then result register).
//
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to waiting for a start byte.
// When the receiver stalls with a result held, the parser stops: a byte already
// in the input register waits there, an empty input register takes one more
// byte, and ready then stays low until the result is taken.
//
module card_track_parser (
    input  logic          clk,
    input  logic          rst_n,
    ctp_item_if.sink      item,
    ctp_result_if.source  result
);

    logic                advance;
    logic                step_en;
    ctp_pkg::item_t      step_item;
    logic                res_valid;
    ctp_pkg::result_t    res;

    ctp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .advance   (advance),
        .step_en   (step_en),
        .step_item (step_item)
    );

    ctp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .step_item (step_item),
        .res_valid (res_valid),
        .res       (res)
    );

    ctp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .result    (result)
    );

endmodule

// ----- tb/ctp_result_checker.sv -----
// Watches both channels of the card track parser, predicts each result and compares it.
`timescale 1ns / 1ps

module ctp_result_checker (
    input  logic  clk,
    input  logic  rst_n,
    ctp_item_if   item_mon,
    ctp_result_if result_mon,
    output int    fail_count,
    output int    pending
);
    import ctp_pkg::*;

    typedef enum logic [3:0] {
        P_IDLE,
        P_PREFIX,
        P_CARD,
        P_LAST,
        P_FIRST,
        P_SKIP,
        P_TRAILER,
        P_ID,
        P_DONE
    } parse_phase_e;

    localparam logic [95:0] TRAILER_TEXT = "491212000000";

    parse_phase_e  phase       = P_IDLE;
    logic [7:0]    byte_pos    = '0;
    logic [4:0]    digits      = '0;
    logic [53:0]   card_acc    = '0;
    logic [29:0]   id_acc      = '0;
    logic [3:0]    trailer_idx = '0;
    result_t       expected_q[$];
    int            errors      = 0;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic result_t failure_at(input logic [8:0] pos);
        result_t r;
        r = '0;
        r.first_char_bad = (pos == 9'd0);
        r.error_position = pos[7:0];
        return r;
    endfunction

    // One byte through the layout; emit is set when the byte closes the card.
    task automatic parse_byte(input item_t it, output bit emit, output result_t res);
        logic [7:0]  c;
        logic [7:0]  pos;
        logic [29:0] id_top;
        emit = 1'b0;
        res = '0;
        c = it.char_code;
        if (it.start_of_card) begin
            phase = P_PREFIX;
            byte_pos = '0;
            digits = '0;
            card_acc = '0;
            id_acc = '0;
            trailer_idx = '0;
        end
        if (phase == P_IDLE || phase == P_DONE)
            return;
        pos = byte_pos;
        // last byte slot is read as a terminator
        if (int'(pos) >= MAX_LEN - 1)
            c = CH_NUL;
        byte_pos = pos + 8'd1;
        case (phase)
            P_PREFIX:
                if (c != ((pos == 8'd0) ? CH_PERCENT : CH_B)) begin
                    emit = 1'b1;
                    res = failure_at({1'b0, pos});
                end else if (pos != 8'd0) begin
                    phase = P_CARD;
                end
            P_CARD:
                if (c == CH_CARET && digits == 5'(CARD_DIGITS)) begin
                    digits = '0;
                    phase = P_LAST;
                end else if (c == CH_CARET || digits >= 5'(CARD_DIGITS) || !is_dec(c)) begin
                    emit = 1'b1;
                    res = failure_at({1'b0, pos});
                end else begin
                    card_acc = card_acc * 54'd10 + 54'(c - "0");
                    digits = digits + 5'd1;
                end
            P_LAST:
                if (c == CH_SLASH) begin
                    phase = P_FIRST;
                end else if (!is_alpha(c) && c != CH_SPACE) begin
                    emit = 1'b1;
                    res = failure_at({1'b0, pos});
                end
            P_FIRST:
                if (c == CH_SPACE) begin
                    phase = P_SKIP;
                end else if (!is_alpha(c)) begin
                    emit = 1'b1;
                    res = failure_at({1'b0, pos});
                end
            P_SKIP:
                if (c == CH_NUL) begin
                    emit = 1'b1;
                    res = failure_at({1'b0, pos});
                end else if (c == CH_CARET) begin
                    trailer_idx = '0;
                    phase = P_TRAILER;
                end
            P_TRAILER:
                if (c == CH_NUL) begin
                    emit = 1'b1;
                    res = failure_at({1'b0, pos});
                end else if (trailer_idx >= 4'(TRAILER_LEN)
                             || c != TRAILER_TEXT[95 - 8*int'(trailer_idx) -: 8]) begin
                    // a wrong trailer byte reports one past its own position
                    emit = 1'b1;
                    res = failure_at({1'b0, pos} + 9'd1);
                end else begin
                    trailer_idx = trailer_idx + 4'd1;
                    if (trailer_idx == 4'(TRAILER_LEN)) begin
                        digits = '0;
                        phase = P_ID;
                    end
                end
            P_ID:
                if (!is_dec(c)) begin
                    emit = 1'b1;
                    res = failure_at({1'b0, pos});
                end else begin
                    id_acc = id_acc * 30'd10 + 30'(c - "0");
                    digits = digits + 5'd1;
                    if (digits >= 5'(SID_DIGITS)) begin
                        id_top = id_acc / 30'd1000000;
                        emit = 1'b1;
                        res.parse_ok = 1'b1;
                        res.card_number = card_acc;
                        res.student_id = id_acc;
                        res.id_in_range = (id_top == 30'd860) || (id_top == 30'd861);
                    end
                end
            default: ;
        endcase
        if (emit)
            phase = P_DONE;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, seen);
            errors++;
        end
    endtask

    // Result side first so a request never matches a prediction made at the same edge.
    always @(posedge clk) begin
        result_t got;
        result_t want;
        result_t predicted;
        bit      emit;
        if (rst_n) begin
            if (result_mon.valid && result_mon.ready) begin
                got.parse_ok = result_mon.parse_ok;
                got.first_char_bad = result_mon.first_char_bad;
                got.error_position = result_mon.error_position;
                got.card_number = result_mon.card_number;
                got.student_id = result_mon.student_id;
                got.id_in_range = result_mon.id_in_range;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual %0h", $time, got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("parse_ok", 64'(want.parse_ok), 64'(got.parse_ok));
                    check_field("first_char_bad", 64'(want.first_char_bad),
                                64'(got.first_char_bad));
                    check_field("error_position", 64'(want.error_position),
                                64'(got.error_position));
                    check_field("card_number", 64'(want.card_number), 64'(got.card_number));
                    check_field("student_id", 64'(want.student_id), 64'(got.student_id));
                    check_field("id_in_range", 64'(want.id_in_range), 64'(got.id_in_range));
                end
            end
            if (item_mon.valid && item_mon.ready) begin
                parse_byte({item_mon.start_of_card, item_mon.char_code}, emit, predicted);
                if (emit)
                    expected_q.push_back(predicted);
            end
        end
        pending <= expected_q.size();
        fail_count <= errors;
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the card track parser: clock, reset, swipe stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ctp_pkg::*;

    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [95:0] TRAILER_STR = "491212000000";

    typedef enum int {
        K_GOOD,
        K_BAD_BYTE,
        K_NUL,
        K_TRAILER_BAD,
        K_TRUNC,
        K_SHORT_CARD,
        K_LONG_CARD,
        K_FIRST_BAD,
        K_NOISE,
        K_LONG
    } card_kind_e;

    logic  clk = 1'b0;
    logic  rst_n;
    bit    no_idle = 1'b0;
    int    sent_items = 0;
    int    stall_cycles = 0;
    int    fail_count;
    int    pending;
    item_t card_items[$];
    item_t directed_q[$];

    ctp_item_if   item_bus ();
    ctp_result_if result_bus ();

    card_track_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    ctp_result_checker result_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_mon   (item_bus),
        .result_mon (result_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // Receiver: random ready bursts plus one long hold-off to back up the parser.
    initial begin
        int burst;
        int ready_cycles;
        bit held;
        ready_cycles = 0;
        held = 1'b0;
        result_bus.ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (!held && ready_cycles >= HOLD_AT) begin
                held = 1'b1;
                burst = HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 17);
                result_bus.ready <= 1'b0;
            end else begin
                burst = $urandom_range(1, 40);
                result_bus.ready <= 1'b1;
            end
            repeat (burst) @(posedge clk);
            ready_cycles += burst;
        end
    end

    function automatic logic [7:0] rand_name_char(input bit allow_space);
        int k;
        if (allow_space && $urandom_range(0, 4) == 0)
            return CH_SPACE;
        k = $urandom_range(0, 51);
        return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 17);
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.start_of_card <= it.start_of_card;
        item_bus.char_code <= it.char_code;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        sent_items++;
    endtask

    // Fills card_items with one swipe string of the given kind.
    task automatic build_card(input card_kind_e kind);
        logic [7:0] txt[$];
        logic [7:0] ch;
        item_t      it;
        int         ndig;
        int         digit_mode;
        int         id_val;
        int         pow10;
        int         tr_at;
        int         k;
        int         keep;
        int         target;
        card_items.delete();
        if (kind == K_NOISE) begin
            repeat ($urandom_range(1, 8)) begin
                it.start_of_card = ($urandom_range(0, 15) == 0);
                it.char_code = 8'($urandom_range(0, 255));
                card_items.push_back(it);
            end
            return;
        end
        txt.push_back(CH_PERCENT);
        txt.push_back(CH_B);
        ndig = (kind == K_SHORT_CARD) ? $urandom_range(0, CARD_DIGITS - 1)
             : (kind == K_LONG_CARD) ? CARD_DIGITS + 1 : CARD_DIGITS;
        digit_mode = $urandom_range(0, 5);
        repeat (ndig) begin
            if (digit_mode == 0)
                txt.push_back("9");
            else if (digit_mode == 1)
                txt.push_back("0");
            else
                txt.push_back(8'("0" + $urandom_range(0, 9)));
        end
        txt.push_back(CH_CARET);
        repeat ($urandom_range(0, 6)) txt.push_back(rand_name_char(1'b1));
        txt.push_back(CH_SLASH);
        repeat ($urandom_range(0, 6)) txt.push_back(rand_name_char(1'b0));
        txt.push_back(CH_SPACE);
        // filler before the trailer caret; long cards may run into the length limit
        target = (kind == K_LONG) ? $urandom_range(226, 262) : txt.size() + $urandom_range(0, 4);
        while (txt.size() < target) begin
            ch = 8'($urandom_range(1, 255));
            if (ch == CH_CARET)
                ch = CH_SPACE;
            txt.push_back(ch);
        end
        txt.push_back(CH_CARET);
        tr_at = txt.size();
        for (int i = 0; i < TRAILER_LEN; i++)
            txt.push_back(TRAILER_STR[95 - 8*i -: 8]);
        case ($urandom_range(0, 5))
            0, 1, 2: id_val = (860 + $urandom_range(0, 1)) * 1000000 + $urandom_range(0, 999999);
            3: begin
                case ($urandom_range(0, 3))
                    0: id_val = 859999999;
                    1: id_val = 862000000;
                    2: id_val = 0;
                    default: id_val = 999999999;
                endcase
            end
            default: id_val = $urandom_range(0, 999999999);
        endcase
        pow10 = 100000000;
        repeat (SID_DIGITS) begin
            txt.push_back(8'("0" + (id_val / pow10) % 10));
            pow10 = pow10 / 10;
        end
        keep = txt.size();
        case (kind)
            K_BAD_BYTE, K_NUL: begin
                k = $urandom_range(1, txt.size() - 1);
                txt[k] = (kind == K_NUL) ? CH_NUL : 8'($urandom_range(0, 255));
                keep = k + 1 + $urandom_range(0, 2);
            end
            K_TRAILER_BAD: begin
                k = tr_at + $urandom_range(0, TRAILER_LEN - 1);
                ch = 8'($urandom_range(1, 255));
                if (ch == txt[k])
                    ch = CH_SLASH;
                txt[k] = ch;
                keep = k + 1 + $urandom_range(0, 2);
            end
            K_FIRST_BAD: begin
                ch = 8'($urandom_range(0, 255));
                if (ch == CH_PERCENT)
                    ch = CH_B;
                txt[0] = ch;
                keep = 1 + $urandom_range(0, 2);
            end
            K_SHORT_CARD, K_LONG_CARD: keep = 3 + ndig + $urandom_range(0, 2);
            K_TRUNC: keep = $urandom_range(1, txt.size() - 1);
            default: ;
        endcase
        while (txt.size() > keep)
            void'(txt.pop_back());
        foreach (txt[i]) begin
            it.start_of_card = (i == 0);
            it.char_code = txt[i];
            card_items.push_back(it);
        end
        // trailing bytes after the card closes are dropped by the parser
        repeat ($urandom_range(0, 2)) begin
            it.start_of_card = 1'b0;
            it.char_code = 8'($urandom_range(0, 255));
            card_items.push_back(it);
        end
    endtask

    initial begin
        int         cards;
        int         r;
        card_kind_e kind;
        item_bus.valid = 1'b0;
        item_bus.start_of_card = 1'b0;
        item_bus.char_code = 8'h00;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before any start, bad first byte, early end, early caret, restart mid-card
        directed_q = '{
            {1'b0, CH_NUL}, {1'b0, 8'hFF}, {1'b1, "X"}, {1'b0, CH_PERCENT},
            {1'b1, CH_NUL},
            {1'b1, CH_PERCENT}, {1'b0, "b"},
            {1'b1, CH_PERCENT}, {1'b0, CH_B}, {1'b0, CH_CARET},
            {1'b1, CH_PERCENT}, {1'b0, CH_B}, {1'b0, 8'h80},
            {1'b1, CH_PERCENT}, {1'b0, CH_B}, {1'b0, "9"}, {1'b0, CH_NUL},
            {1'b1, CH_PERCENT}, {1'b1, CH_PERCENT}, {1'b0, CH_B}, {1'b0, CH_SLASH},
            {1'b0, 8'h7F}
        };
        foreach (directed_q[i])
            send_item(directed_q[i]);

        cards = 0;
        while (sent_items < 850 || cards < 36) begin
            if (cards < 10) begin
                kind = card_kind_e'(cards);
            end else begin
                r = $urandom_range(0, 99);
                kind = (r < 35) ? K_GOOD : (r < 55) ? K_BAD_BYTE : (r < 63) ? K_NUL
                     : (r < 71) ? K_TRAILER_BAD : (r < 77) ? K_TRUNC
                     : (r < 82) ? K_SHORT_CARD : (r < 87) ? K_LONG_CARD
                     : (r < 91) ? K_FIRST_BAD : (r < 97) ? K_NOISE : K_LONG;
            end
            build_card(kind);
            foreach (card_items[i])
                send_item(card_items[i]);
            cards++;
        end

        no_idle <= 1'b1;
        repeat (4) begin
            build_card(K_GOOD);
            foreach (card_items[i])
                send_item(card_items[i]);
        end
        item_bus.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
